>>> design/quad_detuned_saw_oscillator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quad detuned saw oscillator
// Each macro takes a label, the clock, the reset, the property terms and a
// message.
// ----------------------------------------------------------------------------
`ifndef QUAD_DETUNED_SAW_OSCILLATOR_ASSERT_SVH
`define QUAD_DETUNED_SAW_OSCILLATOR_ASSERT_SVH

// check a condition at every clock edge
`define QDSO_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check a consequence in the same cycle
`define QDSO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the following cycle
`define QDSO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/qdso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdso_pkg
// Widths, register codes and shift constants of the quad detuned saw
// oscillator.
// ----------------------------------------------------------------------------
package qdso_pkg;

  localparam int PHASE_W      = 24;
  localparam int FRAC_W       = 8;
  localparam int INT_W        = PHASE_W - FRAC_W;
  localparam int DETUNE_W     = 8;
  localparam int PROD_W       = INT_W + DETUNE_W;
  localparam int SPREAD_SHIFT = 13;
  localparam int SPREAD_W     = PROD_W - SPREAD_SHIFT + 1;
  localparam int TOP_W        = 6;
  localparam int SAMPLE_W     = 8;
  localparam int NUM_DETUNED  = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_DETUNE     = 1'b1;

endpackage

`default_nettype wire

>>> design/qdso_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdso_in_if / qdso_out_if
// Valid/ready channels for sync requests and audio samples.
// ----------------------------------------------------------------------------
interface qdso_in_if;
  logic valid;
  logic ready;
  logic sync_in;

  modport source (output valid, output sync_in, input ready);
  modport sink (input valid, input sync_in, output ready);
endinterface

interface qdso_out_if;
  logic                          valid;
  logic                          ready;
  logic [qdso_pkg::SAMPLE_W-1:0] sample;
  logic                          sync_out;

  modport source (output valid, output sample, output sync_out, input ready);
  modport sink (input valid, input sample, input sync_out, output ready);
endinterface

`default_nettype wire

>>> design/quad_detuned_saw_oscillator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_detuned_saw_oscillator
// Four sawtooth phase accumulators summed into one 8-bit sample per
// transaction; APB registers set pitch and detune spread.
// ----------------------------------------------------------------------------
// channel  direction  payload             handshake
// din      in         sync_in             valid/ready
// dout     out        sample, sync_out    valid/ready
// apb      in/out     phase_step, detune  psel/penable, pready tied high
//
// One transaction per cycle unless the output stalls; the result is registered.
// The phase adders and the four-way top sum set the single-cycle path.
// din.ready stays high while the output register is empty or being taken.
// Sync reset: phases, config, valid to 0, spread to 1; no clearing pass.
// ----------------------------------------------------------------------------
`include "quad_detuned_saw_oscillator_assert.svh"

module quad_detuned_saw_oscillator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  qdso_in_if.sink                              din,
  qdso_out_if.source                           dout,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [qdso_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [qdso_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [qdso_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int PW = qdso_pkg::PHASE_W;
  localparam int FW = qdso_pkg::FRAC_W;
  localparam int IW = qdso_pkg::INT_W;
  localparam int DW = qdso_pkg::DETUNE_W;
  localparam int XW = qdso_pkg::PROD_W;
  localparam int SW = qdso_pkg::SPREAD_W;
  localparam int TW = qdso_pkg::TOP_W;
  localparam int OW = qdso_pkg::SAMPLE_W;
  localparam int ND = qdso_pkg::NUM_DETUNED;
  localparam int CW = qdso_pkg::CFG_DATA_W;

  logic [PW-1:0] phase_step;
  logic [DW-1:0] detune_amount;
  logic [SW-1:0] spread;
  logic [PW-1:0] main_phase;
  logic [IW-1:0] detuned [ND];
  logic          out_valid;
  logic [OW-1:0] sample;
  logic          sync_out;

  logic          cfg_wr;
  logic          reg_sel;
  logic [IW-1:0] mul_step;
  logic [DW-1:0] mul_detune;
  logic [XW-1:0] product;
  logic [SW-1:0] spread_next;

  logic          in_fire;
  logic [IW-1:0] inc [ND];
  logic [IW-1:0] detuned_next [ND];
  logic [PW-1:0] main_base;
  logic [PW-1:0] main_phase_next;
  logic          carry_next;
  logic [OW-1:0] sample_next;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      qdso_pkg::REG_PHASE_STEP: prdata = {{(CW-PW){1'b0}}, phase_step};
      qdso_pkg::REG_DETUNE:     prdata = {{(CW-DW){1'b0}}, detune_amount};
      default:                  prdata = '0;
    endcase
  end

  // spread follows the register values being written
  always_comb begin
    mul_step   = phase_step[PW-1:FW];
    mul_detune = detune_amount;
    if (cfg_wr && reg_sel == qdso_pkg::REG_PHASE_STEP) begin
      mul_step = pwdata[PW-1:FW];
    end
    if (cfg_wr && reg_sel == qdso_pkg::REG_DETUNE) begin
      mul_detune = pwdata[DW-1:0];
    end
    product     = {{(XW-IW){1'b0}}, mul_step} * {{(XW-DW){1'b0}}, mul_detune};
    spread_next = {1'b0, product[XW-1:qdso_pkg::SPREAD_SHIFT]} + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= '0;
      detune_amount <= '0;
      spread        <= SW'(1);
    end else if (cfg_wr) begin
      if (reg_sel == qdso_pkg::REG_PHASE_STEP) begin
        phase_step <= pwdata[PW-1:0];
      end else begin
        detune_amount <= pwdata[DW-1:0];
      end
      spread <= spread_next;
    end
  end

  // phase datapath
  assign in_fire   = din.valid && din.ready;
  assign din.ready = !out_valid || dout.ready;

  always_comb begin
    main_base                     = din.sync_in ? '0 : main_phase;
    {carry_next, main_phase_next} = {1'b0, main_base} + {1'b0, phase_step};
    sample_next = {{(OW-TW){1'b0}}, main_phase_next[PW-1:PW-TW]};
    for (int k = 0; k < ND; k++) begin
      if (k == 0) begin
        inc[k] = phase_step[PW-1:FW] + {{(IW-SW){1'b0}}, spread};
      end else begin
        inc[k] = inc[k-1] + {{(IW-SW){1'b0}}, spread};
      end
      detuned_next[k] = detuned[k] + inc[k];
      sample_next = sample_next + {{(OW-TW){1'b0}}, detuned_next[k][IW-1:IW-TW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase <= '0;
      for (int k = 0; k < ND; k++) begin
        detuned[k] <= '0;
      end
      out_valid <= 1'b0;
    end else if (in_fire) begin
      main_phase <= main_phase_next;
      for (int k = 0; k < ND; k++) begin
        detuned[k] <= detuned_next[k];
      end
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample   <= sample_next;
      sync_out <= carry_next;
    end
  end

  assign dout.valid    = out_valid;
  assign dout.sample   = sample;
  assign dout.sync_out = sync_out;

  `QDSO_ASSERT_NEXT(a_sync_restart, clk, rst, in_fire && din.sync_in, dout.valid && !dout.sync_out && main_phase == $past(phase_step), "sync did not restart main phase")
  `QDSO_ASSERT_NEXT(a_result_loaded, clk, rst, in_fire, dout.valid, "accepted transaction left no result")
  `QDSO_ASSERT_SAME(a_stall_blocks, clk, rst, dout.valid && !dout.ready, !din.ready, "input taken while result stalled")
  `QDSO_ASSERT_ALWAYS(a_spread_nonzero, clk, rst, spread != '0, "detune spread is zero")

endmodule

`default_nettype wire

>>> test/quad_detuned_saw_oscillator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad detuned saw oscillator checker
// Watches the register port and both streams, keeps its own copy of the
// pitch and detune registers and of the four phase accumulators, predicts
// sample and sync_out for every accepted sync transaction, and compares each
// accepted sample transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module quad_detuned_saw_oscillator_checker
  import qdso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  sync_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  sync_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int unsigned           mismatches,
  output int unsigned           outstanding,
  output int unsigned           checked
);

  localparam logic [CFG_ADDR_W-1:0] STEP_ADDR   = {REG_PHASE_STEP, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] DETUNE_ADDR = {REG_DETUNE, 2'b00};

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sync_out;
  } saw_result_t;

  logic [PHASE_W-1:0]  step_reg;
  logic [DETUNE_W-1:0] detune_reg;
  logic [PHASE_W-1:0]  main_acc;
  logic [INT_W-1:0]    detuned_acc [NUM_DETUNED];
  saw_result_t         expected_samples [$];
  saw_result_t         oldest;
  int unsigned         error_count;
  int unsigned         sample_count;

  function automatic saw_result_t advance_oscillator(input logic sync);
    logic [INT_W-1:0]    step_int;
    logic [PROD_W-1:0]   product;
    logic [INT_W-1:0]    spread;
    logic [INT_W-1:0]    inc;
    logic [PHASE_W:0]    total;
    logic [SAMPLE_W-1:0] mix;
    saw_result_t         res;
    step_int = step_reg[PHASE_W-1:FRAC_W];
    product  = PROD_W'(step_int) * PROD_W'(detune_reg);
    spread   = INT_W'((product >> SPREAD_SHIFT) + 1);
    total    = {1'b0, (sync ? {PHASE_W{1'b0}} : main_acc)} + {1'b0, step_reg};
    main_acc = total[PHASE_W-1:0];
    mix      = SAMPLE_W'(main_acc[PHASE_W-1 -: TOP_W]);
    inc      = step_int;
    for (int k = 0; k < NUM_DETUNED; k++) begin
      inc            = inc + spread;
      detuned_acc[k] = detuned_acc[k] + inc;
      mix            = mix + SAMPLE_W'(detuned_acc[k][INT_W-1 -: TOP_W]);
    end
    res.sample   = mix;
    res.sync_out = total[PHASE_W];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      step_reg   = '0;
      detune_reg = '0;
      main_acc   = '0;
      for (int k = 0; k < NUM_DETUNED; k++) begin
        detuned_acc[k] = '0;
      end
      expected_samples.delete();
      error_count  = 0;
      sample_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == STEP_ADDR) begin
          step_reg = pwdata[PHASE_W-1:0];
        end else if (paddr == DETUNE_ADDR) begin
          detune_reg = pwdata[DETUNE_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(advance_oscillator(sync_in));
      end
      if (out_valid && out_ready) begin
        sample_count++;
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: unexpected transaction sample=%h sync_out=%b",
                     $realtime, sample, sync_out);
          end
        end else begin
          oldest = expected_samples.pop_front();
          if (oldest.sample !== sample || oldest.sync_out !== sync_out) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: mismatch sample exp=%h act=%h sync_out exp=%b act=%b",
                       $realtime, oldest.sample, sample, oldest.sync_out, sync_out);
            end
          end
        end
      end
    end
    mismatches  <= error_count;
    outstanding <= expected_samples.size();
    checked     <= sample_count;
  end

endmodule

>>> test/quad_detuned_saw_oscillator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad detuned saw oscillator testbench
// Programs pitch and detune over several settings, extremes included, and
// streams sync requests in random bursts while the sample side stalls on its
// own pattern; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module quad_detuned_saw_oscillator_tb;
  import qdso_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] STEP_ADDR   = {REG_PHASE_STEP, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] DETUNE_ADDR = {REG_DETUNE, 2'b00};
  localparam int unsigned           ITEM_TARGET = 1000;
  localparam int unsigned           TIMEOUT_NS  = 5_000_000;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           checked;
  int unsigned           items_sent;
  int unsigned           syncs_sent;
  int unsigned           settings_used;
  rx_mode_e              rx_mode;
  int unsigned           rx_cycle;

  qdso_in_if  sync_ch ();
  qdso_out_if sample_ch ();

  quad_detuned_saw_oscillator i_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (sync_ch),
    .dout    (sample_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  quad_detuned_saw_oscillator_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sync_ch.valid),
    .in_ready    (sync_ch.ready),
    .sync_in     (sync_ch.sync_in),
    .out_valid   (sample_ch.valid),
    .out_ready   (sample_ch.ready),
    .sample      (sample_ch.sample),
    .sync_out    (sample_ch.sync_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.ready <= 1'b0;
      rx_mode         <= RX_FREE;
      rx_cycle        <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_FREE:     sample_ch.ready <= 1'b1;
        RX_RANDOM:   sample_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: sample_ch.ready <= (rx_cycle[2:0] != 3'd0);
        default:     sample_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sync(input logic sync);
    sync_ch.valid   <= 1'b1;
    sync_ch.sync_in <= sync;
    do @(posedge clk); while (!sync_ch.ready);
    items_sent++;
    syncs_sent += sync;
  endtask

  task automatic hold_sender(input int unsigned cycles);
    sync_ch.valid   <= 1'b0;
    sync_ch.sync_in <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_samples();
    sync_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_voice(input logic [PHASE_W-1:0] step,
                               input logic [DETUNE_W-1:0] detune);
    drain_samples();
    apb_write(STEP_ADDR, {8'($urandom), step});
    apb_write(DETUNE_ADDR, {24'($urandom), detune});
    settings_used++;
  endtask

  task automatic stream_bursts(input int unsigned count, input int unsigned sync_odds);
    int unsigned burst;
    int unsigned gap;
    while (count != 0) begin
      burst = $urandom_range(1, 16);
      if (burst > count) begin
        burst = count;
      end
      repeat (burst) begin
        send_sync($urandom_range(0, sync_odds) == 0);
      end
      count -= burst;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        hold_sender(gap);
      end
    end
  endtask

  initial begin
    logic [PHASE_W-1:0]  step;
    logic [DETUNE_W-1:0] detune;
    items_sent      = 0;
    syncs_sent      = 0;
    settings_used   = 0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sync_ch.valid   = 1'b0;
    sync_ch.sync_in = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, then the register extremes
    send_sync(1'b0);
    send_sync(1'b1);
    send_sync(1'b0);
    program_voice(24'hFFFFFF, 8'hFF);
    send_sync(1'b0);
    send_sync(1'b0);
    send_sync(1'b1);
    send_sync(1'b0);
    send_sync(1'b0);
    program_voice(24'hFFFFFF, 8'h00);
    send_sync(1'b0);
    send_sync(1'b1);
    send_sync(1'b0);
    program_voice(24'h0000FF, 8'hFF);
    send_sync(1'b0);
    send_sync(1'b0);
    send_sync(1'b1);
    program_voice(24'h800000, 8'hFF);
    send_sync(1'b1);
    send_sync(1'b0);
    send_sync(1'b1);
    send_sync(1'b0);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0:       step = 24'($urandom);
        1:       step = 24'($urandom_range(0, 24'h00FFFF));
        2:       step = 24'hFFFFFF - 24'($urandom_range(0, 255));
        3:       step = 24'h800000 ^ 24'($urandom_range(0, 24'h0003FF));
        default: step = 24'($urandom_range(0, 24'h0FFFFF));
      endcase
      case ($urandom_range(0, 3))
        0:       detune = 8'h00;
        1:       detune = 8'hFF;
        default: detune = 8'($urandom);
      endcase
      program_voice(step, detune);
      stream_bursts($urandom_range(30, 120), $urandom_range(1, 20));
    end

    drain_samples();
    $display("%0d sync transactions (%0d with sync set) over %0d register settings,",
             items_sent, syncs_sent, settings_used);
    $display("%0d samples checked with random bursts and output stalls", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/qdso_pkg.sv
design/qdso_if.sv
design/quad_detuned_saw_oscillator.sv
test/quad_detuned_saw_oscillator_checker.sv
test/quad_detuned_saw_oscillator_tb.sv
